### hw/rtl/rcr_pkg.sv
// ----------------------------------------------------------------------------
// rcr_pkg
// Shared types and constants of the range capacity reservation block: item
// opcodes, result status codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package rcr_pkg;

  localparam int OP_W       = 2;
  localparam int SLOT_W     = 10;
  localparam int STATUS_W   = 3;
  localparam int SLOTS_CFG_W = 11;

  // apb register file: one 32-bit register, byte addressed
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [SLOTS_CFG_W-1:0] SLOTS_CFG_RST = 11'd1024;

  typedef enum logic [APB_ADDR_W-3:0] {
    REG_SLOTS_IN_USE = 1'b0
  } reg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_RESERVE = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_GRANTED   = 3'd1,
    ST_SHORT     = 3'd2,
    ST_STOPPED   = 3'd3,
    ST_BAD_RANGE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_CHECK  = 3'b010,
    S_COMMIT = 3'b100
  } seq_state_t;

endpackage

### hw/rtl/rcr_cfg_regs.sv
// ----------------------------------------------------------------------------
// rcr_cfg_regs
// APB register file holding the number of slots open for reservations.
// ----------------------------------------------------------------------------
module rcr_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rcr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rcr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rcr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [rcr_pkg::SLOTS_CFG_W-1:0]   slots_in_use
);
  import rcr_pkg::*;

  logic [SLOTS_CFG_W-1:0] slots_in_use_r;
  logic                   sel_slots;
  logic                   wr_beat;

  assign pready    = 1'b1;
  assign sel_slots = (paddr[APB_ADDR_W-1:2] == REG_SLOTS_IN_USE);
  assign wr_beat   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= SLOTS_CFG_RST;
    end else if (wr_beat && sel_slots) begin
      slots_in_use_r <= pwdata[SLOTS_CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_slots) begin
      prdata = APB_DATA_W'(slots_in_use_r);
    end
  end

  assign slots_in_use = slots_in_use_r;

endmodule

### hw/rtl/range_capacity_reservation.sv
// ----------------------------------------------------------------------------
// range_capacity_reservation
// Per-slot remaining capacity table with first-fit range reservation and a
// latch of the first failing order.
// ----------------------------------------------------------------------------
// Load and restart items, items with the unused opcode, and reserve items
// refused as already stopped or for a bad range are taken while busy stays
// low, and their result beat appears on the next cycle. A reserve over a good
// range walks the capacity memory through its single read port, once to check
// and, if every slot fits, once more to subtract, with busy high during the
// walk; one refused short stops at the first short slot. The result beat of a
// walk comes in the cycle busy falls. Each result is shown for exactly one
// cycle; the receiver must take it then. Stopped, failing order and order
// number show the state after the item and hold until the next item is
// accepted.
module range_capacity_reservation #(
  parameter int SLOTS      = 1024,
  parameter int CAP_BITS   = 30,
  parameter int ORDER_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              start,
  output logic                              busy,
  input  logic [rcr_pkg::OP_W-1:0]          in_op,
  input  logic [rcr_pkg::SLOT_W-1:0]        in_slot_index,
  input  logic [CAP_BITS-1:0]               in_capacity,
  input  logic [CAP_BITS-1:0]               in_demand,
  input  logic [rcr_pkg::SLOT_W-1:0]        in_first_slot,
  input  logic [rcr_pkg::SLOT_W-1:0]        in_last_slot,
  // results
  output logic                              out_valid,
  output logic [rcr_pkg::STATUS_W-1:0]      out_status,
  output logic                              out_stopped,
  output logic [ORDER_BITS-1:0]             out_failing_order,
  output logic [ORDER_BITS-1:0]             out_order_number,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rcr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rcr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rcr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import rcr_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam logic [31:0] SLOTS_W = 32'(SLOTS);
  localparam logic [ORDER_BITS-1:0] ORDER_MAX = '1;

  logic [SLOTS_CFG_W-1:0] slots_in_use;

  rcr_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .slots_in_use (slots_in_use)
  );

  // capacity memory, one write and one registered read a cycle
  logic [CAP_BITS-1:0] mem [SLOTS];
  logic [CAP_BITS-1:0] rd_data_r;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [CAP_BITS-1:0] mem_wdata;

  seq_state_t          state_r, state_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [AW-1:0]       lo_r, lo_nxt;
  logic [AW-1:0]       hi_r, hi_nxt;
  logic [CAP_BITS-1:0] demand_r, demand_nxt;
  logic                issue_done_r, issue_done_nxt;
  logic                pipe_vld_r, pipe_vld_nxt;
  logic                pipe_last_r, pipe_last_nxt;
  logic [AW-1:0]       pipe_addr_r, pipe_addr_nxt;
  logic                stopped_r, stopped_nxt;
  logic [ORDER_BITS-1:0] fail_r, fail_nxt;
  logic [ORDER_BITS-1:0] count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [31:0]         idx_w, lo_w, hi_w, lim_w;
  logic                bad_range;
  logic [ORDER_BITS-1:0] count_inc;

  assign idx_w = 32'(in_slot_index);
  assign lo_w  = 32'(in_first_slot);
  assign hi_w  = 32'(in_last_slot);
  assign lim_w = (32'(slots_in_use) > SLOTS_W) ? SLOTS_W : 32'(slots_in_use);
  assign bad_range = (lo_w > hi_w) || (hi_w >= lim_w);
  assign count_inc = (count_r == ORDER_MAX) ? count_r : count_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    demand_nxt     = demand_r;
    issue_done_nxt = issue_done_r;
    pipe_vld_nxt   = 1'b0;
    pipe_last_nxt  = pipe_last_r;
    pipe_addr_nxt  = pipe_addr_r;
    stopped_nxt    = stopped_r;
    fail_nxt       = fail_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = pipe_addr_r;
    mem_wdata      = rd_data_r - demand_r;

    // read issue shared by both passes; read data comes back registered
    if (state_r != S_IDLE && !issue_done_r) begin
      pipe_vld_nxt   = 1'b1;
      pipe_last_nxt  = (ptr_r == hi_r);
      pipe_addr_nxt  = ptr_r;
      ptr_nxt        = ptr_r + 1'b1;
      issue_done_nxt = (ptr_r == hi_r);
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DONE;
          case (in_op)
            OP_LOAD: begin
              if (idx_w < SLOTS_W) begin
                mem_we    = 1'b1;
                mem_waddr = idx_w[AW-1:0];
                mem_wdata = in_capacity;
              end
            end
            OP_RESERVE: begin
              count_nxt = count_inc;
              if (stopped_r) begin
                out_status_nxt = ST_STOPPED;
              end else if (bad_range) begin
                out_status_nxt = ST_BAD_RANGE;
              end else begin
                out_valid_nxt  = 1'b0;
                state_nxt      = S_CHECK;
                lo_nxt         = lo_w[AW-1:0];
                hi_nxt         = hi_w[AW-1:0];
                ptr_nxt        = lo_w[AW-1:0];
                demand_nxt     = in_demand;
                issue_done_nxt = 1'b0;
              end
            end
            OP_RESTART: begin
              stopped_nxt = 1'b0;
              fail_nxt    = '0;
              count_nxt   = '0;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (pipe_vld_r && (rd_data_r < demand_r)) begin
          stopped_nxt    = 1'b1;
          fail_nxt       = count_r;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_SHORT;
          state_nxt      = S_IDLE;
        end else if (pipe_vld_r && pipe_last_r) begin
          // every slot fits: rewind for the subtract pass
          state_nxt      = S_COMMIT;
          ptr_nxt        = lo_r;
          issue_done_nxt = 1'b0;
          pipe_vld_nxt   = 1'b0;
        end
      end
      S_COMMIT: begin
        if (pipe_vld_r) begin
          mem_we = 1'b1;
          if (pipe_last_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_GRANTED;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      issue_done_r <= 1'b1;
      pipe_vld_r   <= 1'b0;
      stopped_r    <= 1'b0;
      fail_r       <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_done_r <= issue_done_nxt;
      pipe_vld_r   <= pipe_vld_nxt;
      stopped_r    <= stopped_nxt;
      fail_r       <= fail_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    demand_r     <= demand_nxt;
    pipe_last_r  <= pipe_last_nxt;
    pipe_addr_r  <= pipe_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_stopped       = stopped_r;
  assign out_failing_order = fail_r;
  assign out_order_number  = count_r;

endmodule

### hw/rtl/rcr_checker.sv
// ----------------------------------------------------------------------------
// rcr_checker
// Port-level checks on the range capacity reservation block, bound to the
// top level.
// ----------------------------------------------------------------------------
module rcr_checker #(
  parameter int CAP_BITS   = 30,
  parameter int ORDER_BITS = 20
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [rcr_pkg::OP_W-1:0]          in_op,
  input logic                              out_valid,
  input logic [rcr_pkg::STATUS_W-1:0]      out_status,
  input logic                              out_stopped,
  input logic [ORDER_BITS-1:0]             out_failing_order,
  input logic [ORDER_BITS-1:0]             out_order_number
);
  import rcr_pkg::*;

  // anything other than a reserve answers on the very next cycle
  a_quick_items: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op != OP_RESERVE) |=> (out_valid && !busy))
    else $error("non-reserve item did not answer next cycle");

  // a beat only follows an accepted item or a running walk
  a_no_spurious_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result beat without an item");

  a_short_latches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_SHORT) |->
      (out_stopped && out_failing_order == out_order_number))
    else $error("refused short without latching this order");

  a_latch_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stopped) |->
      (out_failing_order == '0 && out_status != ST_STOPPED))
    else $error("failing order set while not stopped");

  a_grant_not_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_GRANTED) |-> (!out_stopped && $fell(busy)))
    else $error("grant while stopped or outside a walk");

endmodule

bind range_capacity_reservation rcr_checker #(
  .CAP_BITS   (CAP_BITS),
  .ORDER_BITS (ORDER_BITS)
) u_rcr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_op             (in_op),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_stopped       (out_stopped),
  .out_failing_order (out_failing_order),
  .out_order_number  (out_order_number)
);
